>>> hw/rtl/rect_table_viewport_query_assert.svh
// Assertion macros shared by the viewport query block.
`ifndef RECT_TABLE_VIEWPORT_QUERY_ASSERT_SVH
`define RECT_TABLE_VIEWPORT_QUERY_ASSERT_SVH

// The property must hold at every rising clock edge outside reset.
`define RTVQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define RTVQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> hw/rtl/rtvq_pkg.sv
package rtvq_pkg;

  localparam int unsigned ViewEntries   = 8;
  localparam int unsigned ObjectEntries = 32;
  localparam int unsigned MaxResults    = 32;
  localparam int unsigned ViewCntW      = $clog2(ViewEntries + 1);
  localparam int unsigned ObjCntW       = $clog2(ObjectEntries + 1);
  localparam int unsigned ResCntW       = $clog2(MaxResults + 1);

  typedef enum logic [2:0] {
    KindAddView  = 3'd0,
    KindDelView  = 3'd1,
    KindFindView = 3'd2,
    KindAddObj   = 3'd3,
    KindDelObj   = 3'd4,
    KindFindObj  = 3'd5,
    KindQuery    = 3'd6,
    KindNone     = 3'd7
  } kind_e;

  typedef struct packed {
    logic [7:0]  id;
    logic [11:0] x;
    logic [11:0] y;
    logic [11:0] w;
    logic [11:0] h;
  } rect_t;

  // Commands from the sequencer to every cell of a chain.
  typedef struct packed {
    logic rotate;  // every cell takes its right neighbor's entry
    logic append;  // cell at the fill count loads the new entry
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    StIdle,
    StScanView,
    StScanObj,
    StQuery,
    StOut
  } state_e;

endpackage

>>> hw/rtl/rtvq_cell.sv
// One table entry; the chain rotates left so entry 0 sees every entry in turn.
module rtvq_cell (
  input  logic                 clk_i,
  input  rtvq_pkg::chain_ctrl_t ctrl_i,
  input  logic                 sel_i,
  input  rtvq_pkg::rect_t      new_i,
  input  rtvq_pkg::rect_t      right_i,
  output rtvq_pkg::rect_t      ent_o
);
  rtvq_pkg::rect_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.append && sel_i) begin
      ent_d = new_i;
    end else if (ctrl_i.rotate) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;
endmodule

>>> hw/rtl/rtvq_chain.sv
// Rows of entry cells. A rotation over the first "len" cells moves entry 1 to
// slot 0 and slot 0 to slot len-1; a "drop" rotation leaves slot 0 out.
module rtvq_view_chain (
  input  logic                              clk_i,
  input  rtvq_pkg::chain_ctrl_t             ctrl_i,
  input  logic [rtvq_pkg::ViewCntW-1:0]     len_i,
  input  logic                              drop_i,
  input  rtvq_pkg::rect_t                   new_i,
  output rtvq_pkg::rect_t                   head_o
);
  localparam int unsigned Depth = rtvq_pkg::ViewEntries;
  localparam int unsigned CntW  = rtvq_pkg::ViewCntW;

  rtvq_pkg::rect_t ents [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic            is_end;
    rtvq_pkg::rect_t right;
    assign is_end = (CntW'(g + 1) == len_i);
    always_comb begin
      if (is_end) begin
        right = drop_i ? ents[g] : ents[0];
      end else if (g + 1 < Depth) begin
        right = ents[(g + 1) % Depth];
      end else begin
        right = ents[g];
      end
    end
    rtvq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .sel_i  (CntW'(g) == len_i),
      .new_i  (new_i),
      .right_i(right),
      .ent_o  (ents[g])
    );
  end

  assign head_o = ents[0];
endmodule

module rtvq_obj_chain (
  input  logic                              clk_i,
  input  rtvq_pkg::chain_ctrl_t             ctrl_i,
  input  logic [rtvq_pkg::ObjCntW-1:0]      len_i,
  input  logic                              drop_i,
  input  rtvq_pkg::rect_t                   new_i,
  output rtvq_pkg::rect_t                   head_o
);
  localparam int unsigned Depth = rtvq_pkg::ObjectEntries;
  localparam int unsigned CntW  = rtvq_pkg::ObjCntW;

  rtvq_pkg::rect_t ents [Depth];

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic            is_end;
    rtvq_pkg::rect_t right;
    assign is_end = (CntW'(g + 1) == len_i);
    always_comb begin
      if (is_end) begin
        right = drop_i ? ents[g] : ents[0];
      end else if (g + 1 < Depth) begin
        right = ents[(g + 1) % Depth];
      end else begin
        right = ents[g];
      end
    end
    rtvq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .sel_i  (CntW'(g) == len_i),
      .new_i  (new_i),
      .right_i(right),
      .ent_o  (ents[g])
    );
  end

  assign head_o = ents[0];
endmodule

>>> hw/rtl/rect_table_viewport_query.sv
// Viewport and object tables held in chains of entry cells that rotate one
// place per cycle, though a query's object walk rotates only while the output
// has room. Every add, delete or find walks the addressed table once; a query
// walks the view chain, then the object chain if the viewport was found. A
// delete drops the hit entry during the walk and shortens the ring for the
// rest of it, keeping order. Results leave through one output register; a
// query holds each overlapping object one step so the final one can carry
// last, stalling the walk while the output is full.
module rect_table_viewport_query (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[2:0], item_id[10:3], pos_x[23:11], pos_y[36:24], size_w[48:37],
  // size_h[60:49], zero pad
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ok[0], obj_valid[1], obj_id[9:2], obj_x[21:10], obj_y[33:22], obj_w[45:34],
  // obj_h[57:46], zero pad
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  localparam int unsigned VW = rtvq_pkg::ViewCntW;
  localparam int unsigned OW = rtvq_pkg::ObjCntW;

  rtvq_pkg::state_e state_q, state_d;
  logic [11:0] aw_q, ah_q;
  logic [2:0]  kind_q;
  logic [7:0]  id_q;
  logic signed [12:0] px_q, py_q;
  logic [11:0] sw_q, sh_q;
  logic [VW-1:0] vcnt_q;
  logic [OW-1:0] ocnt_q;
  logic [OW-1:0] step_q;       // entries left to visit
  logic          hit_q;
  logic [rtvq_pkg::ResCntW-1:0] nres_q;
  rtvq_pkg::rect_t vw_q;       // matched viewport
  logic          ov_q;         // output register full
  logic [63:0]   od_q;
  logic          ol_q;
  // Query results are held one step so the final one can carry last.
  logic          pend_q;
  logic [63:0]   pd_q;

  rtvq_pkg::chain_ctrl_t vctrl, octrl;
  logic vdrop, odrop;
  logic [VW-1:0] vlen;
  logic [OW-1:0] olen;
  rtvq_pkg::rect_t vhead, ohead, newent;

  assign newent = '{id: id_q, x: px_q[11:0], y: py_q[11:0], w: sw_q, h: sh_q};

  rtvq_view_chain u_view (
    .clk_i(clk_i), .ctrl_i(vctrl), .len_i(vlen), .drop_i(vdrop),
    .new_i(newent), .head_o(vhead));
  rtvq_obj_chain u_obj (
    .clk_i(clk_i), .ctrl_i(octrl), .len_i(olen), .drop_i(odrop),
    .new_i(newent), .head_o(ohead));

  logic in_fire, out_free;
  logic is_view, is_add, is_del, scanning;
  rtvq_pkg::rect_t head;
  logic id_hit, area_ok, full, ovl;
  logic [13:0] sx, sy, vxr, vyb, oxr, oyb;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == rtvq_pkg::StIdle);
  assign cfg_ready_o = 1'b1;

  assign is_view = (kind_q == rtvq_pkg::KindAddView) || (kind_q == rtvq_pkg::KindDelView)
                || (kind_q == rtvq_pkg::KindFindView) || (kind_q == rtvq_pkg::KindQuery);
  assign is_add  = (kind_q == rtvq_pkg::KindAddView) || (kind_q == rtvq_pkg::KindAddObj);
  assign is_del  = (kind_q == rtvq_pkg::KindDelView) || (kind_q == rtvq_pkg::KindDelObj);
  // Once a delete has dropped its entry, the rest of the walk rotates a shorter ring.
  assign vlen    = vcnt_q - VW'((state_q == rtvq_pkg::StScanView) && is_del && hit_q);
  assign olen    = ocnt_q - OW'((state_q == rtvq_pkg::StScanObj) && is_del && hit_q);
  assign head    = (state_q == rtvq_pkg::StScanView) ? vhead : ohead;
  assign full    = is_view ? (vcnt_q == VW'(rtvq_pkg::ViewEntries))
                           : (ocnt_q == OW'(rtvq_pkg::ObjectEntries));
  assign id_hit  = (head.id == id_q) && (step_q != '0);
  assign sx = 14'(px_q) + {2'b0, sw_q};
  assign sy = 14'(py_q) + {2'b0, sh_q};
  assign area_ok = !px_q[12] && !py_q[12] && (sx <= {2'b0, aw_q}) && (sy <= {2'b0, ah_q});
  assign vxr = {2'b0, vw_q.x} + {2'b0, vw_q.w};
  assign vyb = {2'b0, vw_q.y} + {2'b0, vw_q.h};
  assign oxr = {2'b0, ohead.x} + {2'b0, ohead.w};
  assign oyb = {2'b0, ohead.y} + {2'b0, ohead.h};
  assign ovl = ({2'b0, ohead.x} < vxr) && (oxr > {2'b0, vw_q.x})
            && ({2'b0, ohead.y} < vyb) && (oyb > {2'b0, vw_q.y});
  assign scanning = (state_q == rtvq_pkg::StScanView) || (state_q == rtvq_pkg::StScanObj);

  // Chain control: rotate during scans and queries; a delete drops the hit slot; an add appends.
  always_comb begin
    vctrl = '0;
    octrl = '0;
    vdrop = 1'b0;
    odrop = 1'b0;
    if (state_q == rtvq_pkg::StScanView && step_q != '0) begin
      vctrl.rotate = 1'b1;
      vdrop = is_del && id_hit && !hit_q;
    end
    if (state_q == rtvq_pkg::StScanObj && step_q != '0) begin
      octrl.rotate = 1'b1;
      odrop = is_del && id_hit && !hit_q;
    end
    if (state_q == rtvq_pkg::StQuery && step_q != '0 && out_free) begin
      octrl.rotate = 1'b1;
    end
    if (state_q == rtvq_pkg::StOut && is_add && !hit_q && !full && area_ok) begin
      if (is_view) vctrl.append = 1'b1;
      else         octrl.append = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtvq_pkg::StIdle: begin
        if (in_fire) begin
          unique case (rtvq_pkg::kind_e'(s_axis_tdata[2:0]))
            rtvq_pkg::KindAddView, rtvq_pkg::KindDelView, rtvq_pkg::KindFindView,
            rtvq_pkg::KindQuery: state_d = rtvq_pkg::StScanView;
            rtvq_pkg::KindAddObj, rtvq_pkg::KindDelObj, rtvq_pkg::KindFindObj:
              state_d = rtvq_pkg::StScanObj;
            default: state_d = rtvq_pkg::StOut;
          endcase
        end
      end
      rtvq_pkg::StScanView: begin
        if (step_q == '0) begin
          state_d = (kind_q == rtvq_pkg::KindQuery && hit_q) ? rtvq_pkg::StQuery
                                                             : rtvq_pkg::StOut;
        end
      end
      rtvq_pkg::StScanObj: if (step_q == '0) state_d = rtvq_pkg::StOut;
      // The object chain always completes its turn so the order is kept.
      rtvq_pkg::StQuery: if (step_q == '0) state_d = rtvq_pkg::StOut;
      rtvq_pkg::StOut: if (out_free) state_d = rtvq_pkg::StIdle;
      default: state_d = rtvq_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtvq_pkg::StIdle;
      aw_q <= 12'd1000;
      ah_q <= 12'd1000;
      vcnt_q <= '0;
      ocnt_q <= '0;
      ov_q <= 1'b0;
      hit_q <= 1'b0;
      step_q <= '0;
      nres_q <= '0;
      vw_q <= '0;
      od_q <= '0;
      ol_q <= 1'b0;
      pend_q <= 1'b0;
      pd_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i) ah_q <= cfg_data_i;
        else             aw_q <= cfg_data_i;
      end
      if (ov_q && m_axis_tready) ov_q <= 1'b0;
      if (in_fire) begin
        hit_q <= 1'b0;
        nres_q <= '0;
      end
      if (state_q == rtvq_pkg::StIdle && in_fire) begin
        unique case (rtvq_pkg::kind_e'(s_axis_tdata[2:0]))
          rtvq_pkg::KindAddView, rtvq_pkg::KindDelView, rtvq_pkg::KindFindView,
          rtvq_pkg::KindQuery: step_q <= OW'(vcnt_q);
          default: step_q <= ocnt_q;
        endcase
      end
      if (scanning && step_q != '0) begin
        step_q <= step_q - 1'b1;
        if (id_hit && !hit_q) begin
          hit_q <= 1'b1;
          if (state_q == rtvq_pkg::StScanView) vw_q <= vhead;
        end
      end
      if (state_q == rtvq_pkg::StScanView && step_q == '0 && kind_q == rtvq_pkg::KindQuery)
        step_q <= ocnt_q;
      if (state_q == rtvq_pkg::StQuery && out_free && step_q != '0) begin
        step_q <= step_q - 1'b1;
        if (ovl && nres_q != rtvq_pkg::ResCntW'(rtvq_pkg::MaxResults)) begin
          pend_q <= 1'b1;
          pd_q   <= {6'b0, ohead.h, ohead.w, ohead.y, ohead.x, ohead.id, 2'b11};
          nres_q <= nres_q + 1'b1;
          // A new overlap shows that the held object is not the final one.
          if (pend_q) begin
            ov_q <= 1'b1;
            od_q <= pd_q;
            ol_q <= 1'b0;
          end
        end
      end
      if (state_q == rtvq_pkg::StOut && out_free) begin
        ov_q <= 1'b1;
        ol_q <= 1'b1;
        if (kind_q == rtvq_pkg::KindQuery) begin
          // The held object is the final result; with none, nothing overlapped or the viewport was not found.
          od_q   <= pend_q ? pd_q : '0;
          pend_q <= 1'b0;
        end else begin
          od_q <= '0;
          unique case (kind_q)
            rtvq_pkg::KindAddView, rtvq_pkg::KindAddObj:
              od_q[0] <= !hit_q && !full && area_ok;
            rtvq_pkg::KindDelView, rtvq_pkg::KindFindView, rtvq_pkg::KindDelObj,
            rtvq_pkg::KindFindObj: od_q[0] <= hit_q;
            default: od_q[0] <= 1'b0;
          endcase
        end
        if (vctrl.append) vcnt_q <= vcnt_q + 1'b1;
        if (octrl.append) ocnt_q <= ocnt_q + 1'b1;
        if (kind_q == rtvq_pkg::KindDelView && hit_q) vcnt_q <= vcnt_q - 1'b1;
        if (kind_q == rtvq_pkg::KindDelObj && hit_q)  ocnt_q <= ocnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= s_axis_tdata[2:0];
      id_q   <= s_axis_tdata[10:3];
      px_q   <= s_axis_tdata[23:11];
      py_q   <= s_axis_tdata[36:24];
      sw_q   <= s_axis_tdata[48:37];
      sh_q   <= s_axis_tdata[60:49];
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;

  `include "rect_table_viewport_query_assert.svh"

  `RTVQ_ASSERT(a_no_accept_busy, (state_q != rtvq_pkg::StIdle) |-> !s_axis_tready,
    "input accepted while busy")
  `RTVQ_ASSERT(a_view_cnt, vcnt_q <= VW'(rtvq_pkg::ViewEntries),
    "view count overflow")
  `RTVQ_ASSERT(a_obj_cnt, ocnt_q <= OW'(rtvq_pkg::ObjectEntries),
    "object count overflow")
  `RTVQ_ASSERT_NEVER(a_res_cap, nres_q > rtvq_pkg::ResCntW'(rtvq_pkg::MaxResults),
    "too many query results")
endmodule
